@@ hw/rtl/dss_pkg.sv @@
`timescale 1ns / 1ps

package dss_pkg;

    // store size and derived widths
    localparam int MAX_REQ = 32;
    localparam int IDX_W   = $clog2(MAX_REQ);
    localparam int CNT_W   = $clog2(MAX_REQ + 1);
    localparam int TRACK_W = 16;
    localparam int DIST_W  = 24;
    localparam int CFG_W   = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // item kinds on the input stream
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_REQ   = 1'b1;

    typedef enum logic [1:0] {
        MODE_FIFO  = 2'd0,
        MODE_SSTF  = 2'd1,
        MODE_SCAN  = 2'd2,
        MODE_CSCAN = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_MODE = 1'b0,
        CFG_DIR  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // one scheduling run, handed from front to back
    typedef struct packed {
        logic [TRACK_W-1:0] start_track;
        logic [CNT_W-1:0]   count;
        logic               drop;
        mode_t              mode;
        logic               dir;
    } cmd_t;

    // store write from the front
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [TRACK_W-1:0] data;
    } wr_t;

    function automatic logic [TRACK_W-1:0] gap(input logic [TRACK_W-1:0] a,
                                               input logic [TRACK_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] s,
                                                  input logic [TRACK_W-1:0] d);
        logic [DIST_W:0] sum;
        sum = {1'b0, s} + {{(DIST_W + 1 - TRACK_W){1'b0}}, d};
        return sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    endfunction

endpackage

@@ hw/rtl/dss_queue.sv @@
`timescale 1ns / 1ps

module dss_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dss_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output dss_pkg::cmd_t out_cmd
);
    import dss_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ hw/rtl/dss_front.sv @@
`timescale 1ns / 1ps

module dss_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [dss_pkg::TRACK_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tuser,
    input  logic                        s_axis_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [dss_pkg::CFG_W-1:0]   cfg_data,
    output dss_pkg::wr_t                wr,
    output logic                        q_valid,
    input  logic                        q_ready,
    output dss_pkg::cmd_t               q_cmd,
    input  logic                        run_done
);
    import dss_pkg::*;

    logic [TRACK_W-1:0] start_reg;
    logic [TRACK_W-1:0] start_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               drop_reg;
    logic               drop_next;
    logic               busy_reg;
    logic               busy_next;
    mode_t              mode_reg;
    logic               dir_reg;
    logic               accept;

    assign s_axis_tready = !busy_reg && q_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // classify the request and update the store bookkeeping
    always_comb
    begin
        start_next = start_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        busy_next  = busy_reg;
        wr.en      = 1'b0;
        wr.addr    = count_reg[IDX_W-1:0];
        wr.data    = s_axis_tdata;
        if (accept)
        begin
            if (s_axis_tuser == KIND_START)
            begin
                start_next = s_axis_tdata;
                count_next = '0;
                drop_next  = 1'b0;
            end
            else if (count_reg < CNT_W'(MAX_REQ))
            begin
                wr.en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                drop_next = 1'b1;
            end
        end
        q_valid           = accept && s_axis_tlast;
        q_cmd.start_track = start_next;
        q_cmd.count       = count_next;
        q_cmd.drop        = drop_next;
        q_cmd.mode        = mode_reg;
        q_cmd.dir         = dir_reg;
        if (q_valid)
        begin
            busy_next = 1'b1;
        end
        else if (run_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            busy_reg  <= busy_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FIFO;
            dir_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MODE: mode_reg <= mode_t'(cfg_data[1:0]);
                CFG_DIR:  dir_reg  <= cfg_data[0];
            endcase
        end
    end

endmodule

@@ hw/rtl/dss_back.sv @@
`timescale 1ns / 1ps

module dss_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dss_pkg::wr_t                wr,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  dss_pkg::cmd_t               q_cmd,
    output logic                        run_done,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dss_pkg::TRACK_W-1:0] out_track,
    output logic [dss_pkg::DIST_W-1:0]  out_dist,
    output logic                        out_status,
    output logic                        out_last
);
    import dss_pkg::*;

    logic [TRACK_W-1:0] store_mem [MAX_REQ];

    state_t             state_reg;
    state_t             state_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [TRACK_W-1:0] head_reg;
    logic [TRACK_W-1:0] head_next;
    logic [DIST_W-1:0]  dist_reg;
    logic [DIST_W-1:0]  dist_next;
    logic               dir_reg;
    logic               dir_next;
    logic [MAX_REQ-1:0] marks_reg;
    logic [MAX_REQ-1:0] marks_next;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   n_next;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]   scan_idx_next;
    logic [CNT_W-1:0]   scan_end_reg;
    logic [CNT_W-1:0]   scan_end_next;
    logic               rd_vld_reg;
    logic               rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [TRACK_W-1:0] rd_data_reg;

    // best candidates: a is the primary pick, b the fallback
    logic               a_found_reg, a_found_next;
    logic [IDX_W-1:0]   a_idx_reg, a_idx_next;
    logic [TRACK_W-1:0] a_trk_reg, a_trk_next;
    logic [TRACK_W-1:0] a_key_reg, a_key_next;
    logic               b_found_reg, b_found_next;
    logic [IDX_W-1:0]   b_idx_reg, b_idx_next;
    logic [TRACK_W-1:0] b_trk_reg, b_trk_next;
    logic [TRACK_W-1:0] b_key_reg, b_key_next;

    logic               out_valid_reg, out_valid_next;
    logic [TRACK_W-1:0] out_track_reg, out_track_next;
    logic [DIST_W-1:0]  out_dist_reg, out_dist_next;
    logic               out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               slot_free;
    logic               do_load;
    logic               do_start;
    logic               do_emit;
    logic               scan_issue;
    logic               scan_done;
    logic               final_pick;
    logic [CNT_W-1:0]   n_inc;

    logic               pending;
    logic [TRACK_W-1:0] d_cur;
    logic               at_or_above;
    logic               at_or_below;
    logic               elig_a;
    logic               elig_b;
    logic [TRACK_W-1:0] key_b;
    logic [IDX_W-1:0]   pick_idx;
    logic [TRACK_W-1:0] pick_trk;

    assign slot_free  = !out_valid_reg || out_ready;
    assign scan_issue = (state_reg == ST_SCAN) && (scan_idx_reg < scan_end_reg);
    assign scan_done  = (scan_idx_reg >= scan_end_reg) && !rd_vld_reg;
    assign n_inc      = n_reg + CNT_W'(1);
    assign final_pick = (n_inc == cmd_reg.count);

    assign out_valid  = out_valid_reg;
    assign out_track  = out_track_reg;
    assign out_dist   = out_dist_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (slot_free)
                begin
                    state_next = (cmd_reg.count == '0) ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = final_pick ? ST_IDLE : ST_SCAN;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_ready  = 1'b0;
        do_load  = 1'b0;
        do_start = 1'b0;
        do_emit  = 1'b0;
        run_done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                do_load = q_valid;
            end
            ST_START:
            begin
                do_start = slot_free;
                run_done = slot_free && (cmd_reg.count == '0);
            end
            ST_SCAN:
            begin
                do_load = 1'b0;
            end
            ST_EMIT:
            begin
                do_emit  = slot_free;
                run_done = slot_free && final_pick;
            end
        endcase
    end

    // classify the entry coming out of the store
    always_comb
    begin
        pending     = !marks_reg[rd_idx_reg];
        d_cur       = gap(rd_data_reg, head_reg);
        at_or_above = (rd_data_reg >= head_reg);
        at_or_below = (rd_data_reg <= head_reg);
        elig_a      = 1'b0;
        elig_b      = 1'b0;
        key_b       = d_cur;
        case (cmd_reg.mode) inside
            MODE_FIFO, MODE_SSTF:
            begin
                elig_a = pending;
            end
            MODE_SCAN:
            begin
                elig_a = pending && (dir_reg ? at_or_above : at_or_below);
                elig_b = pending && (dir_reg ? at_or_below : at_or_above);
            end
            default:
            begin
                elig_a = pending && at_or_above;
                elig_b = pending;
                key_b  = rd_data_reg;
            end
        endcase
        pick_idx = a_found_reg ? a_idx_reg : b_idx_reg;
        pick_trk = a_found_reg ? a_trk_reg : b_trk_reg;
    end

    // run datapath
    always_comb
    begin
        cmd_next        = cmd_reg;
        head_next       = head_reg;
        dist_next       = dist_reg;
        dir_next        = dir_reg;
        marks_next      = marks_reg;
        n_next          = n_reg;
        scan_idx_next   = scan_idx_reg;
        scan_end_next   = scan_end_reg;
        rd_vld_next     = scan_issue;
        a_found_next    = a_found_reg;
        a_idx_next      = a_idx_reg;
        a_trk_next      = a_trk_reg;
        a_key_next      = a_key_reg;
        b_found_next    = b_found_reg;
        b_idx_next      = b_idx_reg;
        b_trk_next      = b_trk_reg;
        b_key_next      = b_key_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_track_next  = out_track_reg;
        out_dist_next   = out_dist_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (do_load)
        begin
            cmd_next = q_cmd;
        end

        // first result is the start track itself
        if (do_start)
        begin
            head_next       = cmd_reg.start_track;
            dist_next       = {{(DIST_W - TRACK_W){1'b0}}, cmd_reg.start_track};
            dir_next        = cmd_reg.dir;
            marks_next      = '0;
            n_next          = '0;
            out_valid_next  = 1'b1;
            out_track_next  = cmd_reg.start_track;
            out_dist_next   = {{(DIST_W - TRACK_W){1'b0}}, cmd_reg.start_track};
            out_status_next = cmd_reg.drop;
            out_last_next   = (cmd_reg.count == '0);
        end

        // walk the store one entry a cycle
        if (scan_issue)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end
        if (rd_vld_reg)
        begin
            if (elig_a && (!a_found_reg || d_cur < a_key_reg))
            begin
                a_found_next = 1'b1;
                a_idx_next   = rd_idx_reg;
                a_trk_next   = rd_data_reg;
                a_key_next   = d_cur;
            end
            if (elig_b && (!b_found_reg || key_b < b_key_reg))
            begin
                b_found_next = 1'b1;
                b_idx_next   = rd_idx_reg;
                b_trk_next   = rd_data_reg;
                b_key_next   = key_b;
            end
        end

        // serve the chosen request
        if (do_emit)
        begin
            dist_next            = sat_add(dist_reg, gap(pick_trk, head_reg));
            head_next            = pick_trk;
            marks_next[pick_idx] = 1'b1;
            n_next               = n_inc;
            if (!a_found_reg && cmd_reg.mode == MODE_SCAN)
            begin
                dir_next = ~dir_reg;
            end
            out_valid_next  = 1'b1;
            out_track_next  = pick_trk;
            out_dist_next   = sat_add(dist_reg, gap(pick_trk, head_reg));
            out_status_next = cmd_reg.drop;
            out_last_next   = final_pick;
        end

        // arm the next selection pass
        if ((do_start && cmd_reg.count != '0) || (do_emit && !final_pick))
        begin
            a_found_next = 1'b0;
            b_found_next = 1'b0;
            if (cmd_reg.mode == MODE_FIFO)
            begin
                scan_idx_next = do_start ? '0 : n_inc;
                scan_end_next = do_start ? CNT_W'(1) : n_inc + CNT_W'(1);
            end
            else
            begin
                scan_idx_next = '0;
                scan_end_next = cmd_reg.count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            scan_idx_reg  <= '0;
            scan_end_reg  <= '0;
            n_reg         <= '0;
            marks_reg     <= '0;
            a_found_reg   <= 1'b0;
            b_found_reg   <= 1'b0;
            dir_reg       <= 1'b1;
            cmd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_vld_next;
            scan_idx_reg  <= scan_idx_next;
            scan_end_reg  <= scan_end_next;
            n_reg         <= n_next;
            marks_reg     <= marks_next;
            a_found_reg   <= a_found_next;
            b_found_reg   <= b_found_next;
            dir_reg       <= dir_next;
            cmd_reg       <= cmd_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        head_reg       <= head_next;
        dist_reg       <= dist_next;
        a_idx_reg      <= a_idx_next;
        a_trk_reg      <= a_trk_next;
        a_key_reg      <= a_key_next;
        b_idx_reg      <= b_idx_next;
        b_trk_reg      <= b_trk_next;
        b_key_reg      <= b_key_next;
        out_track_reg  <= out_track_next;
        out_dist_reg   <= out_dist_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // request store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
        if (scan_issue)
        begin
            rd_data_reg <= store_mem[scan_idx_reg[IDX_W-1:0]];
            rd_idx_reg  <= scan_idx_reg[IDX_W-1:0];
        end
    end

endmodule

@@ hw/rtl/disk_seek_scheduler.sv @@
`timescale 1ns / 1ps
// Disk seek scheduler.
// Input stream: tuser is the item kind (start track or pending request), tdata the
// track, tlast closes the list and starts a scheduling run. Up to 32 requests are
// kept; extra ones are dropped and flagged in the results' status bit.
// Config channel: index 0 selects the mode (fifo, shortest seek, scan, circular
// scan), index 1 the initial scan direction. Write only while the block is idle.
// Output stream: tdata carries the served track and the running head travel,
// tuser the drop status, tlast the final result of the run. A run emits the
// start track first, then one result per stored request.
// Each result after the start track comes from a pick that walks the stored
// requests through the single read port one entry a cycle; fifo mode reads
// only the next entry in order.
// The input stays stalled from the closing item until the run's last result has
// been handed to the output register; loading otherwise takes one cycle an item.
// A stalled receiver holds the output register, and the run waits before loading its next result.
// Reset empties the store count, clears the start track, sets fifo mode and an
// increasing direction, and drops any run in progress.
module disk_seek_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] track
    input  logic        s_axis_tuser,   // [0] kind
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] served_track, [39:16] total_distance
    output logic        m_axis_tuser,   // [0] status
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);
    import dss_pkg::*;

    wr_t                wr;
    logic               fq_valid;
    logic               fq_ready;
    cmd_t               fq_cmd;
    logic               bq_valid;
    logic               bq_ready;
    cmd_t               bq_cmd;
    logic               run_done;
    logic [TRACK_W-1:0] out_track;
    logic [DIST_W-1:0]  out_dist;

    dss_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .wr            (wr),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_cmd         (fq_cmd),
        .run_done      (run_done)
    );

    dss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_cmd   (bq_cmd)
    );

    dss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .q_valid    (bq_valid),
        .q_ready    (bq_ready),
        .q_cmd      (bq_cmd),
        .run_done   (run_done),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_track  (out_track),
        .out_dist   (out_dist),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    // pack result fields, lowest field first
    assign m_axis_tdata = {out_dist, out_track};

endmodule

@@ verif/disk_seek_scheduler_test.sv @@
`timescale 1ns / 1ps

module disk_seek_scheduler_test;
    import dss_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE      = 40;
    localparam int IDLE_PCT    = 6;
    localparam int RANDOM_ITEMS = 100;

    // which side of the head a pick may come from
    typedef enum int {
        PICK_ANY,
        PICK_UP,
        PICK_DOWN
    } pick_t;

    // one visited track as it leaves the block
    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [DIST_W-1:0]  travel;
        logic               status;
        logic               eor;
    } visit_t;

    // predicts the service order of every run and checks the visits against it
    class seek_order_board;
        mode_t              mode;
        logic               dir;
        logic [TRACK_W-1:0] store [MAX_REQ];
        int                 count;
        logic [TRACK_W-1:0] start_trk;
        logic               dropped;
        visit_t             visits_due [$];
        int                 errors;

        function new();
            mode      = MODE_FIFO;
            dir       = 1'b1;
            count     = 0;
            start_trk = '0;
            dropped   = 1'b0;
            errors    = 0;
        endfunction

        function void note_config(cfg_reg_t idx, logic [1:0] data);
            if (idx == CFG_MODE)
                mode = mode_t'(data);
            else
                dir = data[0];
        endfunction

        function int span(int a, int b);
            return (a > b) ? (a - b) : (b - a);
        endfunction

        // nearest pending request, earliest entry on ties
        function int nearest(logic [MAX_REQ-1:0] done, int head, pick_t sel);
            int best;
            int bestd;
            int t;
            int d;
            int i;
            best  = -1;
            bestd = 0;
            for (i = 0; i < count; i++)
            begin
                t = store[i];
                if (done[i])
                    continue;
                if (sel == PICK_UP && t < head)
                    continue;
                if (sel == PICK_DOWN && t > head)
                    continue;
                d = span(t, head);
                if (best < 0 || d < bestd)
                begin
                    best  = i;
                    bestd = d;
                end
            end
            return best;
        endfunction

        // accepted input request: update the store, schedule a run on last
        function void take_item(logic kind, logic [TRACK_W-1:0] trk, logic lst);
            logic [MAX_REQ-1:0] done;
            int                 head;
            int                 sum;
            logic               sweep;
            int                 pick;
            int                 n;
            int                 i;
            visit_t             v;
            if (kind == KIND_START)
            begin
                start_trk = trk;
                count     = 0;
                dropped   = 1'b0;
            end
            else if (count < MAX_REQ)
            begin
                store[count] = trk;
                count++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (!lst)
                return;

            // the start track is always visited first
            head     = start_trk;
            sum      = start_trk;
            sweep    = dir;
            done     = '0;
            v.track  = start_trk;
            v.travel = sum[DIST_W-1:0];
            v.status = dropped;
            v.eor    = 1'b0;
            visits_due.push_back(v);

            for (n = 0; n < count; n++)
            begin
                case (mode)
                    MODE_FIFO: pick = n;
                    MODE_SSTF: pick = nearest(done, head, PICK_ANY);
                    MODE_SCAN:
                    begin
                        pick = nearest(done, head, sweep ? PICK_UP : PICK_DOWN);
                        if (pick < 0)
                        begin
                            sweep = !sweep;
                            pick  = nearest(done, head, sweep ? PICK_UP : PICK_DOWN);
                        end
                    end
                    default:
                    begin
                        pick = nearest(done, head, PICK_UP);
                        // nothing ahead: wrap to the lowest pending track
                        if (pick < 0)
                        begin
                            for (i = 0; i < count; i++)
                            begin
                                if (!done[i] && (pick < 0 || store[i] < store[pick]))
                                    pick = i;
                            end
                        end
                    end
                endcase
                if (pick < 0)
                    break;
                sum = sum + span(store[pick], head);
                if (sum > int'(DIST_MAX))
                    sum = int'(DIST_MAX);
                head       = store[pick];
                done[pick] = 1'b1;
                v.track    = store[pick];
                v.travel   = sum[DIST_W-1:0];
                visits_due.push_back(v);
            end

            v     = visits_due.pop_back();
            v.eor = 1'b1;
            visits_due.push_back(v);
        endfunction

        // accepted result: compare with the oldest visit due
        function void check_visit(visit_t got);
            visit_t want;
            if (visits_due.size() == 0)
            begin
                $error("unexpected result: served_track %0d", got.track);
                errors++;
                return;
            end
            want = visits_due.pop_front();
            if (got.track != want.track)
            begin
                $error("served_track: expected %0d, actual %0d", want.track, got.track);
                errors++;
            end
            if (got.travel != want.travel)
            begin
                $error("total_distance: expected %0d, actual %0d", want.travel, got.travel);
                errors++;
            end
            if (got.status != want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.eor != want.eor)
            begin
                $error("end_of_run: expected %0d, actual %0d", want.eor, got.eor);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [1:0]  cfg_data = '0;

    seek_order_board board = new();
    bit              calm = 1'b0;
    int              items_sent = 0;
    int              quiet = 0;
    visit_t          got;

    disk_seek_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver stalls now and then, never during a calm stretch
    always @(posedge clk)
    begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // result check and watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.track  = m_axis_tdata[15:0];
                got.travel = m_axis_tdata[39:16];
                got.status = m_axis_tuser;
                got.eor    = m_axis_tlast;
                board.check_visit(got);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick_track(logic [15:0] center);
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            4:       return center;
            default: return center + 16'($urandom_range(0, 64)) - 16'd32;
        endcase
    endfunction

    // one input request; valid stays high into the next request
    task automatic send(logic kind, logic [15:0] trk, logic lst);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= trk;
        s_axis_tuser  <= kind;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.take_item(kind, trk, lst);
        items_sent++;
    endtask

    // a list of requests around one track, optionally opened by a start item
    task automatic send_batch(logic with_start, int n, logic close);
        logic [15:0] center;
        int          i;
        center = 16'($urandom);
        if (with_start)
            send(KIND_START, center, close && n == 0);
        for (i = 0; i < n; i++)
            send(KIND_REQ, pick_track(center), close && i == n - 1);
    endtask

    // wait until every visit has come back and the block has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.visits_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_put(cfg_reg_t idx, logic [1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.note_config(idx, data);
    endtask

    // write both registers in random order
    task automatic set_config(mode_t m, logic d);
        if ($urandom_range(0, 1))
        begin
            cfg_put(CFG_MODE, m);
            cfg_put(CFG_DIR, {1'($urandom_range(0, 1)), d});
        end
        else
        begin
            cfg_put(CFG_DIR, {1'($urandom_range(0, 1)), d});
            cfg_put(CFG_MODE, m);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int  phase;
        int  roll;
        bit  overflow_done;
        phase         = 0;
        overflow_done = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fifo: requests before any start, last on a start item, extremes
        drain();
        set_config(MODE_FIFO, 1'b1);
        send(KIND_REQ, 16'd100, 1'b0);
        send(KIND_REQ, 16'hFFFF, 1'b1);
        send(KIND_START, 16'hFFFF, 1'b1);
        send(KIND_REQ, 16'hFFFF, 1'b0);
        send(KIND_REQ, 16'h0000, 1'b1);

        // shortest seek: tie goes to earliest, request at the head, repeated run
        drain();
        set_config(MODE_SSTF, 1'b1);
        send(KIND_START, 16'd1000, 1'b0);
        send(KIND_REQ, 16'd1010, 1'b0);
        send(KIND_REQ, 16'd990, 1'b0);
        send(KIND_REQ, 16'd1000, 1'b0);
        send(KIND_REQ, 16'd0, 1'b1);
        send(KIND_REQ, 16'd5, 1'b1);

        // scan downward first, equal tracks, reversal at the bottom
        drain();
        set_config(MODE_SCAN, 1'b0);
        send(KIND_START, 16'd500, 1'b0);
        send(KIND_REQ, 16'd600, 1'b0);
        send(KIND_REQ, 16'd400, 1'b0);
        send(KIND_REQ, 16'd500, 1'b0);
        send(KIND_REQ, 16'd450, 1'b0);
        send(KIND_REQ, 16'd400, 1'b1);

        // circular scan ignores direction and wraps to the lowest track
        drain();
        set_config(MODE_CSCAN, 1'b0);
        send(KIND_START, 16'd300, 1'b0);
        send(KIND_REQ, 16'd100, 1'b0);
        send(KIND_REQ, 16'd400, 1'b0);
        send(KIND_REQ, 16'd100, 1'b0);
        send(KIND_REQ, 16'd300, 1'b1);

        // random phases, each under its own setting
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            drain();
            calm = (phase == 2);
            set_config(mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3))
            begin
                roll = $urandom_range(0, 99);
                if (!overflow_done)
                begin
                    // more requests than the store holds
                    send_batch(1'b1, MAX_REQ + 3, 1'b1);
                    overflow_done = 1'b1;
                end
                else if (roll < 70)
                begin
                    send_batch(1'b1, ($urandom_range(0, 9) == 0) ? MAX_REQ :
                               $urandom_range(0, 8), 1'b1);
                end
                else if (roll < 82)
                begin
                    send_batch(1'b0, $urandom_range(1, 4), 1'b1);
                end
                else if (roll < 94)
                begin
                    send_batch(1'($urandom_range(0, 1)), $urandom_range(0, 4), 1'b0);
                end
                else
                begin
                    send(KIND_START, 16'($urandom), 1'b1);
                end
            end
            phase++;
        end

        drain();
        if (board.errors == 0 && board.visits_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
